/* src/opi_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the pose integrator.
package opi_pkg;

  // Default configuration of the CORDIC core
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 24;

  // Fixed field widths
  localparam int LIN_W = 20;   // forward step
  localparam int ANG_W = 24;   // heading / heading change
  localparam int POS_W = 32;   // Q16.16 position
  localparam int CS_W  = 32;   // cos/sin in Q30
  localparam int TAB_N = 24;   // entries in the arctangent table

  // 1/K in Q30, starting x of the rotation
  localparam logic signed [CS_W-1:0] KINV_Q30 = 32'sd652032874;

  // Controller to datapath commands
  typedef struct packed {
    logic ld;     // latch a word, set up the rotation
    logic clr;    // clear pose to origin
    logic iter;   // one CORDIC micro-rotation
    logic mulx;   // multiply step by cos
    logic addx;   // accumulate x, multiply step by sin
    logic addy;   // accumulate y, advance heading
    logic wout;   // load output register
  } opi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic iter_done;  // current micro-rotation is the last one
  } opi_sts_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/opi_if.sv */
// Valid/ready channel interfaces for odometry step words and pose words.
interface opi_in_if;
  import opi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LIN_W-1:0] linear_step;
  logic signed [ANG_W-1:0] angular_step;
  logic                    reset_pose;

  modport source (output valid, linear_step, angular_step, reset_pose, input ready);
  modport sink   (input valid, linear_step, angular_step, reset_pose, output ready);
endinterface

interface opi_out_if;
  import opi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic        [ANG_W-1:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

/* src/opi_ctrl.sv */
// Sequencing state machine of the pose integrator.
module opi_ctrl
  import opi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_reset_pose,
  input  logic     out_ready,
  input  opi_sts_t sts,
  output opi_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ITER = 6'b000010,
    S_MULX = 6'b000100,
    S_ADDX = 6'b001000,
    S_ADDY = 6'b010000,
    S_FIN  = 6'b100000
  } opi_state_t;

  opi_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // output register can take a new word when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_reset_pose) begin
            cmd.clr   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            cmd.ld    = 1'b1;
            state_nxt = S_ITER;
          end
        end
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_done) state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mulx  = 1'b1;
        state_nxt = S_ADDX;
      end
      S_ADDX: begin
        cmd.addx  = 1'b1;
        state_nxt = S_ADDY;
      end
      S_ADDY: begin
        cmd.addy  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.wout  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.wout) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/opi_dp.sv */
// Datapath: pose accumulators, iterative CORDIC, shared multiplier, output register.
module opi_dp
  import opi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  opi_cmd_t                cmd,
  input  logic signed [LIN_W-1:0] in_linear_step,
  input  logic signed [ANG_W-1:0] in_angular_step,
  output opi_sts_t                sts,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic        [ANG_W-1:0] out_heading
);

  localparam int AB   = ANGLE_BITS;
  localparam int CW   = $clog2(CORDIC_STEPS);
  localparam int PW   = LIN_W + 1 + CS_W;   // product width
  localparam int RW   = PW - 30;            // rounded product width
  localparam logic signed [AB:0] QUARTER = (AB + 1)'(1) << (AB - 2);
  localparam logic signed [AB:0] HALF    = (AB + 1)'(1) << (AB - 1);

  // pose state
  logic signed [POS_W-1:0] x_acc_r, y_acc_r;
  logic        [ANG_W-1:0] heading_r;
  // per-word working registers
  logic signed [LIN_W:0]   lin_r;
  logic        [ANG_W-1:0] dang_r;
  logic signed [CS_W-1:0]  cx_r, cy_r;
  logic signed [AB:0]      z_r;
  logic        [CW-1:0]    cnt_r;
  logic signed [PW-1:0]    prod_r;
  // output register
  logic signed [POS_W-1:0] ox_r, oy_r;
  logic        [ANG_W-1:0] oh_r;

  // heading rescaled to the CORDIC angle width
  logic [AB-1:0] ang_cv;
  if (AB >= ANG_W) begin : g_up
    assign ang_cv = AB'(heading_r) << (AB - ANG_W);
  end else begin : g_dn
    assign ang_cv = heading_r[ANG_W-1 -: AB];
  end

  // range reduction into [-1/4, 1/4) turn
  logic signed [AB:0] z0, z_red;
  logic               flip;
  always_comb begin
    z0 = $signed({ang_cv[AB-1], ang_cv});
    flip  = 1'b0;
    z_red = z0;
    if (z0 >= QUARTER) begin
      z_red = z0 - HALF;
      flip  = 1'b1;
    end else if (z0 < -QUARTER) begin
      z_red = z0 + HALF;
      flip  = 1'b1;
    end
  end

  // one micro-rotation
  logic        [31:0]     da_full;
  logic signed [AB:0]     da;
  logic signed [CS_W-1:0] sx, sy;
  assign da_full = atan_turn32(5'(cnt_r)) >> (32 - AB);
  assign da      = $signed({1'b0, da_full[AB-1:0]});
  assign sx      = cy_r >>> cnt_r;
  assign sy      = cx_r >>> cnt_r;
  assign sts.iter_done = (cnt_r == CW'(CORDIC_STEPS - 1));

  // shared multiplier: cos on the first pass, sin on the second
  logic signed [CS_W-1:0] mop;
  logic signed [PW-1:0]   prod_nxt;
  assign mop      = cmd.mulx ? cx_r : cy_r;
  assign prod_nxt = lin_r * mop;

  // round half up, then saturating add to an accumulator
  function automatic logic signed [POS_W-1:0] acc_sat(input logic signed [POS_W-1:0] a,
                                                      input logic signed [PW-1:0] p);
    logic signed [PW-1:0]    pr;
    logic signed [RW-1:0]    r;
    logic signed [POS_W:0]   s;
    logic signed [POS_W-1:0] res;
    pr = p + (PW'(1) << 29);
    r  = pr[PW-1:30];
    s  = $signed({a[POS_W-1], a}) + (POS_W + 1)'(r);
    if (s[POS_W] != s[POS_W-1])
      res = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    else
      res = s[POS_W-1:0];
    return res;
  endfunction

  // pose accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      x_acc_r   <= '0;
      y_acc_r   <= '0;
      heading_r <= '0;
    end else begin
      if (cmd.addx) x_acc_r <= acc_sat(x_acc_r, prod_r);
      if (cmd.addy) begin
        y_acc_r   <= acc_sat(y_acc_r, prod_r);
        heading_r <= heading_r + dang_r;
      end
    end
  end

  // CORDIC and product registers
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      // a flipped half-plane negates cos and sin; fold it into the step
      lin_r  <= flip ? -(LIN_W + 1)'(in_linear_step) : (LIN_W + 1)'(in_linear_step);
      dang_r <= in_angular_step;
      cx_r   <= KINV_Q30;
      cy_r   <= '0;
      z_r    <= z_red;
      cnt_r  <= '0;
    end else if (cmd.iter) begin
      if (!z_r[AB]) begin
        cx_r <= cx_r - sx;
        cy_r <= cy_r + sy;
        z_r  <= z_r - da;
      end else begin
        cx_r <= cx_r + sx;
        cy_r <= cy_r - sy;
        z_r  <= z_r + da;
      end
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.mulx || cmd.addx) prod_r <= prod_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.wout) begin
      ox_r <= x_acc_r;
      oy_r <= y_acc_r;
      oh_r <= heading_r;
    end
  end

  assign out_pos_x   = ox_r;
  assign out_pos_y   = oy_r;
  assign out_heading = oh_r;

endmodule

/* src/odometry_pose_integrator_unit.sv */
// Top level of the dead-reckoning pose integrator: controller, datapath, channels.
// Each accepted word runs the iterative CORDIC, one micro-rotation per cycle, then two
// passes through the one shared multiplier; x, y and heading are updated and the pose
// is loaded into the output register once it is free. A reset-pose word clears the
// pose and goes straight to that load. No new word is taken until the last pose is
// loaded; one is taken while a finished pose waits in the output register.
// Synchronous active-low reset zeroes the pose and empties the output register.
module odometry_pose_integrator_unit
  import opi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  opi_in_if.sink    in_ch,
  opi_out_if.source out_ch
);

  opi_cmd_t cmd;
  opi_sts_t sts;

  opi_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_reset_pose (in_ch.reset_pose),
    .out_ready     (out_ch.ready),
    .sts           (sts),
    .cmd           (cmd),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid)
  );

  opi_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_linear_step  (in_ch.linear_step),
    .in_angular_step (in_ch.angular_step),
    .sts             (sts),
    .out_pos_x       (out_ch.pos_x),
    .out_pos_y       (out_ch.pos_y),
    .out_heading     (out_ch.heading)
  );

  // block is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // output register only loads when it is empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wout |-> (!out_ch.valid || out_ch.ready))
    else $error("pending pose overwritten");

  // a loaded pose is presented on the next cycle
  a_wout_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wout |=> out_ch.valid)
    else $error("pose loaded but not presented");

endmodule
